// ----- hw/rtl/badm_pkg.sv -----
// shared types, codes and address constants for the banked address decoder
`default_nettype none

package badm_pkg;

	// routing targets
	localparam logic [3:0] TGT_ROM   = 4'd0;
	localparam logic [3:0] TGT_MEM   = 4'd1;
	localparam logic [3:0] TGT_ERAM  = 4'd2;
	localparam logic [3:0] TGT_CONST = 4'd3;
	localparam logic [3:0] TGT_DIV   = 4'd4;
	localparam logic [3:0] TGT_IF    = 4'd5;
	localparam logic [3:0] TGT_IE    = 4'd6;
	localparam logic [3:0] TGT_DMA   = 4'd7;
	localparam logic [3:0] TGT_NONE  = 4'd8;

	// mapper kinds
	localparam logic [1:0] MAPPER_NONE = 2'd0;
	localparam logic [1:0] MAPPER_MBC1 = 2'd1;

	// configuration register indexes
	localparam logic CFG_MAPPER_KIND   = 1'b0;
	localparam logic CFG_ROM_SIZE_CODE = 1'b1;

	localparam int CFG_DATA_W = 3;

	// request kinds
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// address map boundaries (inclusive upper ends)
	localparam logic [15:0] ADDR_RAMEN_END  = 16'h1FFF;
	localparam logic [15:0] ADDR_BANKLO_END = 16'h3FFF;
	localparam logic [15:0] ADDR_BANKHI_END = 16'h5FFF;
	localparam logic [15:0] ADDR_ROM_END    = 16'h7FFF;
	localparam logic [15:0] ADDR_VRAM_END   = 16'h9FFF;
	localparam logic [15:0] ADDR_ERAM_END   = 16'hBFFF;
	localparam logic [15:0] ADDR_WRAM_END   = 16'hDFFF;
	localparam logic [15:0] ADDR_ECHO_END   = 16'hFDFF;
	localparam logic [15:0] ADDR_OAM_END    = 16'hFE9F;
	localparam logic [15:0] ADDR_UNUSED_END = 16'hFEFF;
	localparam logic [15:0] ADDR_ECHO_OFS   = 16'h2000;
	localparam logic [15:0] ADDR_DIV        = 16'hFF04;
	localparam logic [15:0] ADDR_TAC        = 16'hFF07;
	localparam logic [15:0] ADDR_IF         = 16'hFF0F;
	localparam logic [15:0] ADDR_DMA        = 16'hFF46;
	localparam logic [15:0] ADDR_IE         = 16'hFFFF;

	localparam logic [3:0] RAMEN_KEY = 4'hA;
	localparam logic [2:0] ROM_CODE_MAX = 3'd6;

	typedef struct packed {
		logic        req_type;
		logic [15:0] bus_addr;
		logic [7:0]  wdata;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  target;
		logic [20:0] phys_addr;
		logic        write_enable;
		logic [7:0]  out_data;
		logic [7:0]  dma_page;
		logic        ram_on;
	} out_item_t;

	typedef struct packed {
		logic [1:0] mapper_kind;
		logic [2:0] rom_size_code;
	} cfg_t;

	typedef struct packed {
		logic [6:0] prg_bank;
		logic [1:0] ram_bank;
		logic       ram_enable_flag;
		logic       banking_mode;
	} mbc_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/badm_decode.sv -----
// address decode and mbc1 bank register update for one bus access
`default_nettype none

module badm_decode (
	input  wire badm_pkg::in_item_t   item,
	input  wire badm_pkg::cfg_t       cfg,
	input  wire badm_pkg::mbc_state_t state,
	output badm_pkg::out_item_t       result,
	output badm_pkg::mbc_state_t      next_state
);
	import badm_pkg::*;

	logic        mbc1;
	logic        nomap;
	logic [2:0]  code;
	logic [6:0]  bank_mask;
	logic [6:0]  rd_bank;
	logic [15:0] a;
	logic [7:0]  v;

	assign a     = item.bus_addr;
	assign v     = item.wdata;
	assign mbc1  = (cfg.mapper_kind == MAPPER_MBC1);
	assign nomap = (cfg.mapper_kind == MAPPER_NONE);
	assign code  = (cfg.rom_size_code > ROM_CODE_MAX) ? ROM_CODE_MAX : cfg.rom_size_code;
	assign bank_mask = 7'((8'd2 << code) - 8'd1);
	// bank 0 in the switchable window reads as bank 1
	assign rd_bank = (state.prg_bank == 7'd0) ? 7'd1 : state.prg_bank;

	// bank registers
	always_comb begin
		next_state = state;
		if (item.req_type == REQ_WRITE && a <= ADDR_ROM_END && mbc1) begin
			if (a <= ADDR_RAMEN_END) begin
				next_state.ram_enable_flag = (v[3:0] == RAMEN_KEY);
			end else if (a <= ADDR_BANKLO_END) begin
				next_state.prg_bank = {state.prg_bank[6:5], v[4:0]} & bank_mask;
			end else if (a <= ADDR_BANKHI_END) begin
				if (state.banking_mode) begin
					next_state.ram_bank = v[1:0];
				end else begin
					next_state.prg_bank = {v[1:0], state.prg_bank[4:0]} & bank_mask;
				end
			end else begin
				next_state.banking_mode = v[0];
			end
		end
	end

	// routing
	always_comb begin
		result              = '0;
		result.target       = TGT_NONE;
		result.ram_on       = next_state.ram_enable_flag;
		if (item.req_type == REQ_READ) begin
			if (a <= ADDR_BANKLO_END) begin
				result.target    = TGT_ROM;
				result.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ROM_END) begin
				result.target    = TGT_ROM;
				result.phys_addr = mbc1 ? {rd_bank, a[13:0]} : {5'd0, a};
			end else if (a <= ADDR_VRAM_END) begin
				result.target    = TGT_MEM;
				result.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ERAM_END) begin
				if (nomap) begin
					result.target    = TGT_ERAM;
					result.phys_addr = {8'd0, a[12:0]};
				end else if (mbc1) begin
					result.target    = TGT_ERAM;
					result.phys_addr = {6'd0, state.ram_bank, a[12:0]};
				end else begin
					result.target   = TGT_CONST;
					result.out_data = 8'hFF;
				end
			end else if (a <= ADDR_WRAM_END) begin
				result.target    = TGT_MEM;
				result.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ECHO_END) begin
				result.target    = TGT_MEM;
				result.phys_addr = {5'd0, a - ADDR_ECHO_OFS};
			end else if (a <= ADDR_OAM_END) begin
				result.target    = TGT_MEM;
				result.phys_addr = {5'd0, a};
			end else if (a <= ADDR_UNUSED_END) begin
				result.target = TGT_CONST;
			end else begin
				result.target    = TGT_MEM;
				result.phys_addr = {5'd0, a};
			end
		end else begin
			if (a <= ADDR_ROM_END) begin
				// mapper register writes only, nothing routed
				result.target = TGT_NONE;
			end else if (a <= ADDR_VRAM_END) begin
				result.target       = TGT_MEM;
				result.phys_addr    = {5'd0, a};
				result.write_enable = 1'b1;
				result.out_data     = v;
			end else if (a <= ADDR_ERAM_END) begin
				if (nomap) begin
					result.target       = TGT_ERAM;
					result.phys_addr    = {8'd0, a[12:0]};
					result.write_enable = 1'b1;
					result.out_data     = v;
				end else if (mbc1) begin
					result.target       = TGT_ERAM;
					result.phys_addr    = {6'd0, state.ram_bank, a[12:0]};
					result.write_enable = 1'b1;
					result.out_data     = v;
				end
			end else if (a <= ADDR_WRAM_END) begin
				result.target       = TGT_MEM;
				result.phys_addr    = {5'd0, a};
				result.write_enable = 1'b1;
				result.out_data     = v;
			end else if (a <= ADDR_ECHO_END) begin
				result.target       = TGT_MEM;
				result.phys_addr    = {5'd0, a - ADDR_ECHO_OFS};
				result.write_enable = 1'b1;
				result.out_data     = v;
			end else if (a <= ADDR_OAM_END) begin
				result.target       = TGT_MEM;
				result.phys_addr    = {5'd0, a};
				result.write_enable = 1'b1;
				result.out_data     = v;
			end else if (a <= ADDR_UNUSED_END) begin
				result.target = TGT_NONE;
			end else begin
				result.phys_addr    = {5'd0, a};
				result.write_enable = 1'b1;
				result.out_data     = v;
				case (a)
					ADDR_DIV: result.target = TGT_DIV;
					ADDR_TAC: begin
						result.target   = TGT_MEM;
						result.out_data = {5'd0, v[2:0]};
					end
					ADDR_IF:  result.target = TGT_IF;
					ADDR_DMA: begin
						result.target   = TGT_DMA;
						result.dma_page = v;
					end
					ADDR_IE:  result.target = TGT_IE;
					default:  result.target = TGT_MEM;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/banked_address_decoder_mbc1.sv -----
// top level of the mbc1 banked address decoder: input stage, state, result register
//
// Takes one cpu bus access per item on the input channel (in_valid/in_stall,
// payload in_item) and returns exactly one routing result per item on the
// output channel (out_valid/out_stall, payload out_item).
// The input register takes the item, the decode and bank logic runs, and the
// result register loads it when free. Throughput is one item per cycle while
// the receiver does not hold out_stall; the mapper bank registers are updated
// in the same cycle that the item is decoded, so the next item sees them
// without a bubble.
// When the receiver holds out_stall, the result register keeps its item and
// the input register fills; in_stall then rises once both are occupied.
// The cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// mapper kind (index 0) and rom size code (index 1); it is always ready and
// should only be used while no item is in flight.
// Reset clears the pipeline valid bits, the configuration registers and the
// rom bank, ram bank, ram enable and banking mode registers to zero.
`default_nettype none

module banked_address_decoder_mbc1 (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire badm_pkg::in_item_t          in_item,
	output logic                             out_valid,
	input  wire                              out_stall,
	output badm_pkg::out_item_t              out_item,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire                              cfg_index,
	input  wire [badm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import badm_pkg::*;

	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res_q;
	logic       res_valid_q;
	cfg_t       cfg_q;
	mbc_state_t state_q;
	out_item_t  result;
	mbc_state_t next_state;
	logic       res_free;
	logic       s1_move;

	assign res_free  = !res_valid_q || !out_stall;
	assign s1_move   = valid_s1 && res_free;
	assign in_stall  = valid_s1 && !res_free;
	assign cfg_ready = 1'b1;
	assign out_valid = res_valid_q;
	assign out_item  = res_q;

	badm_decode u_decode (
		.item       (item_s1),
		.cfg        (cfg_q),
		.state      (state_q),
		.result     (result),
		.next_state (next_state)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			res_q <= result;
		end
	end

	// mapper state advances with each decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_move) begin
			state_q <= next_state;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAPPER_KIND:   cfg_q.mapper_kind   <= cfg_data[1:0];
				CFG_ROM_SIZE_CODE: cfg_q.rom_size_code <= cfg_data;
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// a stalled input means the input register is holding an item
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall without a held item");

	// without the mbc1 mapper the bank registers never move
	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && cfg_q.mapper_kind != MAPPER_MBC1) |=> $stable(state_q))
		else $error("bank state changed without mbc1 mapper");

	// rom, constant and unrouted results are never writes
	a_no_write_ro: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && (res_q.target == TGT_ROM || res_q.target == TGT_CONST
			|| res_q.target == TGT_NONE)) |-> !res_q.write_enable)
		else $error("write enable on a read-only target");

	// a dma page only comes with a dma start
	a_dma_page: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.dma_page != 8'd0) |-> (res_q.target == TGT_DMA))
		else $error("dma page without dma target");

	// a stalled result register that is not released keeps its item
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && out_stall) |=> (res_valid_q && $stable(res_q)))
		else $error("result register lost a stalled item");

endmodule

`default_nettype wire

// ----- tb/route_checker.sv -----
// watches the access and result channels of the banked decoder, predicts each routing and checks it
module route_checker (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	input  wire                               in_stall,
	input  badm_pkg::in_item_t                in_item,
	input  wire                               out_valid,
	input  wire                               out_stall,
	input  badm_pkg::out_item_t               out_item,
	input  wire                               cfg_valid,
	input  wire                               cfg_ready,
	input  wire                               cfg_index,
	input  wire [badm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                fail_count,
	output int                                pending
);
	import badm_pkg::*;

	logic [1:0] mapper_kind;
	logic [2:0] rom_code;
	mbc_state_t mbc;
	out_item_t  routes_due[$];
	out_item_t  want;
	int         err_cnt;

	function automatic logic [6:0] bank_wrap_mask();
		logic [2:0] c;
		c = (rom_code > ROM_CODE_MAX) ? ROM_CODE_MAX : rom_code;
		return 7'((8'd2 << c) - 8'd1);
	endfunction

	// routes one access and applies its effect on the mapper registers
	function automatic out_item_t route_access(in_item_t acc);
		out_item_t   r;
		logic [15:0] a;
		logic [7:0]  v;
		logic [6:0]  b;
		logic        is_mbc1;
		logic        no_map;
		a = acc.bus_addr;
		v = acc.wdata;
		is_mbc1 = (mapper_kind == MAPPER_MBC1);
		no_map = (mapper_kind == MAPPER_NONE);
		r = '0;
		r.target = TGT_NONE;
		if (acc.req_type == REQ_READ) begin
			if (a <= ADDR_BANKLO_END) begin
				r.target = TGT_ROM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ROM_END) begin
				r.target = TGT_ROM;
				if (is_mbc1) begin
					// bank zero is read as bank one
					b = (mbc.prg_bank != 7'd0) ? mbc.prg_bank : 7'd1;
					r.phys_addr = {b, a[13:0]};
				end else begin
					r.phys_addr = {5'd0, a};
				end
			end else if (a <= ADDR_VRAM_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ERAM_END) begin
				if (no_map) begin
					r.target = TGT_ERAM;
					r.phys_addr = {8'd0, a[12:0]};
				end else if (is_mbc1) begin
					r.target = TGT_ERAM;
					r.phys_addr = {6'd0, mbc.ram_bank, a[12:0]};
				end else begin
					r.target = TGT_CONST;
					r.out_data = 8'hFF;
				end
			end else if (a <= ADDR_WRAM_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ECHO_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a - ADDR_ECHO_OFS};
			end else if (a <= ADDR_OAM_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_UNUSED_END) begin
				r.target = TGT_CONST;
				r.out_data = 8'h00;
			end else begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end
		end else begin
			if (a <= ADDR_ROM_END) begin
				if (is_mbc1) begin
					if (a <= ADDR_RAMEN_END) begin
						mbc.ram_enable_flag = (v[3:0] == RAMEN_KEY);
					end else if (a <= ADDR_BANKLO_END) begin
						mbc.prg_bank = {mbc.prg_bank[6:5], v[4:0]} & bank_wrap_mask();
					end else if (a <= ADDR_BANKHI_END) begin
						if (mbc.banking_mode)
							mbc.ram_bank = v[1:0];
						else
							mbc.prg_bank = {v[1:0], mbc.prg_bank[4:0]} & bank_wrap_mask();
					end else begin
						mbc.banking_mode = v[0];
					end
				end
			end else if (a <= ADDR_VRAM_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ERAM_END) begin
				if (no_map) begin
					r.target = TGT_ERAM;
					r.phys_addr = {8'd0, a[12:0]};
				end else if (is_mbc1) begin
					r.target = TGT_ERAM;
					r.phys_addr = {6'd0, mbc.ram_bank, a[12:0]};
				end
			end else if (a <= ADDR_WRAM_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end else if (a <= ADDR_ECHO_END) begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a - ADDR_ECHO_OFS};
			end else if (a <= ADDR_UNUSED_END) begin
				if (a <= ADDR_OAM_END) begin
					r.target = TGT_MEM;
					r.phys_addr = {5'd0, a};
				end
			end else if (a == ADDR_DIV) begin
				r.target = TGT_DIV;
				r.phys_addr = {5'd0, a};
			end else if (a == ADDR_IF) begin
				r.target = TGT_IF;
				r.phys_addr = {5'd0, a};
			end else if (a == ADDR_DMA) begin
				r.target = TGT_DMA;
				r.phys_addr = {5'd0, a};
				r.dma_page = v;
			end else if (a == ADDR_IE) begin
				r.target = TGT_IE;
				r.phys_addr = {5'd0, a};
			end else begin
				r.target = TGT_MEM;
				r.phys_addr = {5'd0, a};
			end
			if (r.target != TGT_NONE) begin
				r.write_enable = 1'b1;
				// timer control keeps only its three low bits
				r.out_data = (a == ADDR_TAC) ? {5'd0, v[2:0]} : v;
			end
		end
		r.ram_on = mbc.ram_enable_flag;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
		if (exp_v != got_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
			err_cnt++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapper_kind = MAPPER_NONE;
			rom_code = '0;
			mbc = '0;
			routes_due.delete();
			err_cnt = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MAPPER_KIND)
					mapper_kind = cfg_data[1:0];
				else
					rom_code = cfg_data;
			end
			if (in_valid && !in_stall)
				routes_due.push_back(route_access(in_item));
			if (out_valid && !out_stall) begin
				if (routes_due.size() == 0) begin
					$error("result item with nothing expected: target 0x%0h addr 0x%0h",
						out_item.target, out_item.phys_addr);
					err_cnt++;
				end else begin
					want = routes_due.pop_front();
					check_field("target", want.target, out_item.target);
					check_field("phys_addr", want.phys_addr, out_item.phys_addr);
					check_field("write_enable", want.write_enable, out_item.write_enable);
					check_field("out_data", want.out_data, out_item.out_data);
					check_field("dma_page", want.dma_page, out_item.dma_page);
					check_field("ram_on", want.ram_on, out_item.ram_on);
				end
			end
			fail_count <= err_cnt;
			pending <= routes_due.size();
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// top of the decoder testbench: clock, reset, access and config stimulus, verdict
module tb_top;
	import badm_pkg::*;

	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 145;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	in_item_t              in_item;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid;
	logic                  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	wire                   in_stall;
	wire                   out_valid;
	wire                   cfg_ready;
	out_item_t             out_item;
	int                    fail_count;
	int                    pending;
	bit                    idle_on;
	bit                    stall_on;

	// mapper kind and rom size code per phase, extremes and out-of-range codes included
	logic [1:0] phase_mapper [PHASES] = '{2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd3, 2'd0, 2'd1, 2'd0};
	logic [2:0] phase_code   [PHASES] = '{3'd6, 3'd0, 3'd7, 3'd3, 3'd2, 3'd5, 3'd6, 3'd1, 3'd4};

	logic [15:0] bound_addrs [30] = '{
		16'h0000, 16'h1FFF, 16'h2000, 16'h3FFF, 16'h4000, 16'h5FFF, 16'h6000, 16'h7FFF,
		16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000, 16'hDFFF, 16'hE000, 16'hFDFF,
		16'hFE00, 16'hFE9F, 16'hFEA0, 16'hFEFF, 16'hFF00, 16'hFF02, 16'hFF04, 16'hFF07,
		16'hFF0F, 16'hFF46, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF
	};

	banked_address_decoder_mbc1 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	route_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < 27);
	end

	initial begin
		#4000000;
		$display("tb_top: FAIL");
		$finish;
	end

	function automatic in_item_t access(logic kind, logic [15:0] addr, logic [7:0] data);
		in_item_t it;
		it.req_type = kind;
		it.bus_addr = addr;
		it.wdata = data;
		return it;
	endfunction

	// mostly mapper writes, banked rom and ext ram traffic and map boundaries, rest noise
	function automatic in_item_t rand_access();
		in_item_t    it;
		int unsigned pick;
		it.req_type = 1'($urandom_range(1));
		it.bus_addr = 16'($urandom);
		it.wdata = 8'($urandom);
		pick = $urandom_range(99);
		if (pick < 25) begin
			it.req_type = REQ_WRITE;
			it.bus_addr = 16'($urandom_range(ADDR_ROM_END));
			if ($urandom_range(3) == 0)
				it.wdata[3:0] = RAMEN_KEY;
		end else if (pick < 40) begin
			it.bus_addr = 16'($urandom_range(ADDR_ROM_END, 16'h4000));
		end else if (pick < 55) begin
			it.bus_addr = 16'($urandom_range(ADDR_ERAM_END, 16'hA000));
		end else if (pick < 75) begin
			it.bus_addr = bound_addrs[$urandom_range(29)];
		end
		return it;
	endfunction

	// entered and left at a falling edge; valid stays up when the next item follows
	task automatic send_access(in_item_t it);
		while (idle_on && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic configure(logic [1:0] mapper, logic [2:0] code);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_MAPPER_KIND;
		cfg_data <= {1'b0, mapper};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= CFG_ROM_SIZE_CODE;
		cfg_data <= code;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		in_item_t directed [$];
		in_valid = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAPPER_KIND;
		cfg_data = '0;
		idle_on = 1'b1;
		stall_on = 1'b1;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed = '{
			access(REQ_READ,  16'h0000, 8'h00),
			access(REQ_READ,  16'h3FFF, 8'hFF),
			access(REQ_READ,  16'h4000, 8'h00),   // bank zero reads as bank one
			access(REQ_WRITE, 16'h0000, 8'hFA),   // enable key in low nibble only
			access(REQ_WRITE, 16'h2000, 8'hFF),
			access(REQ_WRITE, 16'h4000, 8'h03),   // high bank bits in rom mode
			access(REQ_READ,  16'h7FFF, 8'h00),
			access(REQ_WRITE, 16'h6000, 8'h01),
			access(REQ_WRITE, 16'h5FFF, 8'h02),   // ram bank in ram mode
			access(REQ_READ,  16'hA000, 8'h00),
			access(REQ_WRITE, 16'hBFFF, 8'h55),
			access(REQ_WRITE, 16'h1FFF, 8'h0B),
			access(REQ_WRITE, 16'h3FFF, 8'h00),
			access(REQ_READ,  16'h8000, 8'h00),
			access(REQ_WRITE, 16'hE000, 8'hFF),   // echo mirror
			access(REQ_READ,  16'hFDFF, 8'h00),
			access(REQ_WRITE, 16'hFE9F, 8'hA5),
			access(REQ_READ,  16'hFEA0, 8'h00),   // unused area
			access(REQ_WRITE, 16'hFEFF, 8'h5A),
			access(REQ_WRITE, ADDR_DIV, 8'h81),
			access(REQ_WRITE, ADDR_TAC, 8'hFF),
			access(REQ_WRITE, ADDR_IF,  8'h1F),
			access(REQ_WRITE, ADDR_DMA, 8'hC3),
			access(REQ_WRITE, ADDR_IE,  8'hAA),
			access(REQ_WRITE, 16'hFF02, 8'h81),   // serial port is plain io
			access(REQ_READ,  ADDR_DMA, 8'h00)
		};

		for (int p = 0; p < PHASES; p++) begin
			configure(phase_mapper[p], phase_code[p]);
			// one phase runs with no idling on either side
			idle_on = (p != 2);
			stall_on = (p != 2);
			if (p == 0) begin
				foreach (directed[i])
					send_access(directed[i]);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_access(rand_access());
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
